/* design/u8u2_pkg.sv */
// ---------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ---------------------------------------------------------------------------
package u8u2_pkg;

	localparam int unsigned MAX_CAPACITY = 65535;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned UNIT_W   = 16;
	localparam int unsigned SIZE_W   = 17;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned STATUS_W = 2;

	// capacity clamp, worked out at elaboration
	localparam logic [UNIT_W-1:0] CAP_LIMIT = UNIT_W'(MAX_CAPACITY);
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

	// lead byte classes
	localparam logic [2:0] LEAD2_TAG = 3'h6;   // 110x_xxxx
	localparam logic [3:0] LEAD3_TAG = 4'hE;   // 1110_xxxx
	localparam logic [4:0] LEAD2_MASK = 5'h1F;
	localparam logic [3:0] LEAD3_MASK = 4'h0F;
	localparam logic [5:0] CONT_MASK  = 6'h3F;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_COUNT_ONLY = 1'b0,
		REG_CAPACITY   = 1'b1
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_BAD_CONV  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         bytes_left;
		logic [UNIT_W-1:0]  acc;
		logic [COUNT_W-1:0] unit_count;
		logic               dropping;
	} dec_state_t;

	typedef struct packed {
		logic               valid;
		logic [UNIT_W-1:0]  code_unit;
		status_t            status;
		logic [SIZE_W-1:0]  size;
		logic               last;
	} dec_result_t;

	typedef struct packed {
		logic              count_only;
		logic [UNIT_W-1:0] capacity;
	} dec_cfg_t;

endpackage

/* design/u8u2_step.sv */
// ---------------------------------------------------------------------------
// u8u2_step
// Next-state and result logic for one accepted byte.
// ---------------------------------------------------------------------------
module u8u2_step
	import u8u2_pkg::*;
(
	input  dec_cfg_t          cfg,
	input  dec_state_t        cur,
	input  logic [BYTE_W-1:0] in_byte,
	output dec_state_t        nxt,
	output dec_result_t       res
);

	logic [UNIT_W-1:0]  cap;
	logic [UNIT_W-1:0]  cont_acc;
	logic [1:0]         cont_left;
	logic               fin;
	logic [UNIT_W-1:0]  fin_unit;
	logic [COUNT_W-1:0] count_inc;

	assign cap       = (cfg.capacity > CAP_LIMIT) ? CAP_LIMIT : cfg.capacity;
	assign cont_acc  = {cur.acc[UNIT_W-7:0], in_byte[5:0] & CONT_MASK};
	assign cont_left = cur.bytes_left - 2'd1;
	assign count_inc = (cur.unit_count != COUNT_LIMIT) ? cur.unit_count + 1'b1
	                                                    : cur.unit_count;

	always_comb begin
		nxt      = cur;
		res      = '0;
		fin      = 1'b0;
		fin_unit = '0;

		if (cur.dropping) begin
			if (in_byte == '0) begin
				nxt = '0;
			end
		end else if (cur.bytes_left != 2'd0) begin
			nxt.acc        = cont_acc;
			nxt.bytes_left = cont_left;
			if (cont_left == 2'd0) begin
				fin      = 1'b1;
				fin_unit = cont_acc;
			end
		end else if (in_byte == '0) begin
			res.valid = 1'b1;
			res.size  = SIZE_W'(cur.unit_count) + 1'b1;
			res.last  = 1'b1;
			nxt       = '0;
			nxt.dropping = 1'b1;
		end else if (!in_byte[7]) begin
			fin      = 1'b1;
			fin_unit = UNIT_W'(in_byte);
		end else if (in_byte[7:5] == LEAD2_TAG) begin
			nxt.acc        = UNIT_W'(in_byte[4:0] & LEAD2_MASK);
			nxt.bytes_left = 2'd1;
		end else if (in_byte[7:4] == LEAD3_TAG) begin
			nxt.acc        = UNIT_W'(in_byte[3:0] & LEAD3_MASK);
			nxt.bytes_left = 2'd2;
		end else begin
			res.valid  = 1'b1;
			res.status = cfg.count_only ? ST_BAD_COUNT : ST_BAD_CONV;
			res.last   = 1'b1;
			nxt        = '0;
			nxt.dropping = 1'b1;
		end

		// unit complete
		if (fin) begin
			nxt.bytes_left = 2'd0;
			nxt.acc        = '0;
			if (cfg.count_only) begin
				nxt.unit_count = count_inc;
			end else if (cur.unit_count >= cap) begin
				res.valid  = 1'b1;
				res.status = ST_FULL;
				res.last   = 1'b1;
				nxt        = '0;
				nxt.dropping = 1'b1;
			end else begin
				res.valid      = 1'b1;
				res.code_unit  = fin_unit;
				nxt.unit_count = count_inc;
			end
		end
	end

endmodule

/* design/utf8_to_ucs2_decoder_unit.sv */
// ---------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit
// Streaming UTF-8 to 16-bit BMP code unit decoder with size reporting.
// ---------------------------------------------------------------------------
// Takes one UTF-8 byte per item, a new item every clock while the output slot
// is free or draining, so the sustained rate is one byte per cycle; the only
// bound is the single output register, which refills in the cycle it drains.
// Results are registered on acceptance. The decode state (bytes still
// expected, partial unit, unit count, drop flag) is updated on every accepted
// byte; a byte yields zero or one result. In convert mode each finished
// unit goes out with status OK; if the unit count has reached capacity a
// FULL result with tlast goes out instead. A zero lead byte ends the
// string and emits size = units + 1 with tlast. Bad leads emit an error
// with tlast. After any tlast result, bytes are swallowed until the next
// zero byte, which resets the string silently. Configuration writes are
// taken any time but must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit
	import u8u2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// config write port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata,

	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] in_byte

	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // [15:0] code_unit, [32:16] size, rest zero
	output logic [1:0]  m_tuser,    // [1:0] status
	output logic        m_tlast     // last
);

	dec_cfg_t    cfg_q;
	dec_state_t  st_q;
	dec_state_t  st_nxt;
	dec_result_t res;

	logic              out_valid_q;
	logic [UNIT_W-1:0] out_unit_q;
	status_t           out_status_q;
	logic [SIZE_W-1:0] out_size_q;
	logic              out_last_q;

	logic in_acc;
	logic out_load;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_only <= 1'b0;
			cfg_q.capacity   <= CAP_LIMIT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COUNT_ONLY: cfg_q.count_only <= cfg_wdata[0];
				REG_CAPACITY:   cfg_q.capacity   <= cfg_wdata;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Accept whenever the output slot is free or draining this cycle
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = in_acc && res.valid;

	u8u2_step u_step (
		.cfg     (cfg_q),
		.cur     (st_q),
		.in_byte (s_tdata),
		.nxt     (st_nxt),
		.res     (res)
	);

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_unit_q   <= res.code_unit;
			out_status_q <= res.status;
			out_size_q   <= res.size;
			out_last_q   <= res.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_size_q, out_unit_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// End and error results carry no code unit
	a_last_no_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_unit_q == '0)
		else $error("last result carries a code unit");

	// Size appears only on a successful end result
	a_size_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_size_q != '0 |-> out_last_q && out_status_q == ST_OK)
		else $error("size on a non-end result");

	// Any last result leaves the decoder dropping bytes
	a_drop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.last |=> st_q.dropping)
		else $error("not dropping after last result");

	// Nothing is emitted while dropping
	a_quiet_drop: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.dropping |-> !res.valid)
		else $error("result while dropping");

endmodule
